// ===== rtl/core/in_order_receive_reorder_buffer_unit_assert.svh =====
// Assertion macros used by the reorder buffer unit.
`ifndef IN_ORDER_RECEIVE_REORDER_BUFFER_UNIT_ASSERT_SVH
`define IN_ORDER_RECEIVE_REORDER_BUFFER_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define IORB_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define IORB_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/core/iorb_pkg.sv =====
// ----------------------------------------------------------------------------
// iorb_pkg
// Types and constants of the in-order receive reorder buffer.
// ----------------------------------------------------------------------------
package iorb_pkg;
	localparam int unsigned SLOTS = 16;
	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam int unsigned CNT_W = $clog2(SLOTS + 1);

	localparam logic [3:0] K_DATA   = 4'd0;
	localparam logic [3:0] K_ACK    = 4'd1;
	localparam logic [3:0] K_SYN    = 4'd2;
	localparam logic [3:0] K_SYNACK = 4'd3;
	localparam logic [3:0] K_FIN    = 4'd4;
	localparam logic [3:0] K_FINACK = 4'd5;
	localparam logic [3:0] K_INFO   = 4'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_SHIFT,
		ST_REL,
		ST_COMPACT,
		ST_INFO,
		ST_REPLY,
		ST_FWD
	} state_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] seq;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] pay;
	} entry_t;

	// Room left in the buffer, masked to the four-bit result field.
	function automatic logic [3:0] room(input logic [CNT_W-1:0] cnt);
		logic [CNT_W:0] cap;
		logic [CNT_W:0] diff;
		begin
			cap = (CNT_W + 1)'(SLOTS - 1);
			diff = cap - {1'b0, cnt};
			room = ({1'b0, cnt} >= cap) ? 4'd0 : diff[3:0];
		end
	endfunction
endpackage

// ===== rtl/core/iorb_store.sv =====
// ----------------------------------------------------------------------------
// iorb_store
// Held entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module iorb_store (
	input  logic                         clk,
	input  logic                         we,
	input  logic [iorb_pkg::IDX_W-1:0]   waddr,
	input  iorb_pkg::entry_t             wdata,
	input  logic [iorb_pkg::IDX_W-1:0]   raddr,
	output iorb_pkg::entry_t             rdata
);
	iorb_pkg::entry_t mem_q [iorb_pkg::SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/in_order_receive_reorder_buffer_unit.sv =====
// A forwarded ACK or FINACK and the acknowledgement of an old sequence appear
// in the cycle after acceptance; a stored item is read and then acted on entry
// by entry in each pass through the find, shift, release and compact states.
// Throughput: one item at a time; busy stays high until the last result is out.
// Results come with a strobe, at most one per cycle; the receiver cannot stall.
// Reset: asynchronous; clears the held count, last delivered and the sequencer.
// ----------------------------------------------------------------------------
// in_order_receive_reorder_buffer_unit
// Sorted insertion and in-order release of packet headers.
// ----------------------------------------------------------------------------
`include "in_order_receive_reorder_buffer_unit_assert.svh"
module in_order_receive_reorder_buffer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  kind,
	input  logic [31:0] sequence_req,
	input  logic [31:0] ack_number,
	input  logic [31:0] source_addr,
	input  logic [31:0] dest_addr,
	input  logic [31:0] payload_tag,
	output logic        strobe,
	output logic        toward_network,
	output logic [3:0]  out_kind,
	output logic [31:0] out_sequence,
	output logic [31:0] out_ack,
	output logic [31:0] out_source,
	output logic [31:0] out_dest,
	output logic [3:0]  free_slots,
	output logic [31:0] out_payload,
	output logic        last_of_run
);
	localparam int unsigned IW = iorb_pkg::IDX_W;
	localparam int unsigned CW = iorb_pkg::CNT_W;

	iorb_pkg::state_t state_q, state_d;
	logic [31:0]      last_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    ptr_q;   // scan position
	logic [CW-1:0]    sh_q;    // insert point
	logic [CW-1:0]    rel_q;   // entries released in this run
	logic             ph_q;    // high when rdata holds the entry read for this step
	iorb_pkg::entry_t in_q;
	logic [31:0]      ack_q;

	logic             we;
	logic [IW-1:0]    waddr, raddr;
	iorb_pkg::entry_t wdata, rdata;

	logic          storable, is_fwd, has_room, accept;
	logic          at_end, at_hole, pack_done;
	logic [CW-1:0] src_idx;
	logic [3:0]    reply_kind;
	logic [31:0]   cmp_b;
	logic          cmp_lt, cmp_eq;

	iorb_store u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign storable = (kind == iorb_pkg::K_DATA) || (kind == iorb_pkg::K_SYN)
		|| (kind == iorb_pkg::K_FIN);
	assign is_fwd = (kind == iorb_pkg::K_ACK) || (kind == iorb_pkg::K_FINACK);
	assign has_room = cnt_q < CW'(iorb_pkg::SLOTS - 1);
	assign busy = (state_q != iorb_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign at_end = (ptr_q == cnt_q);
	assign at_hole = (ptr_q == sh_q);
	assign src_idx = ptr_q + rel_q;
	assign pack_done = (rel_q == '0) || (src_idx == cnt_q);
	assign reply_kind = (in_q.kind == iorb_pkg::K_DATA) ? iorb_pkg::K_ACK
		: (in_q.kind == iorb_pkg::K_SYN) ? iorb_pkg::K_SYNACK : iorb_pkg::K_FINACK;

	// Shared compare unit: one stored sequence against a target.
	always_comb begin
		cmp_b = (state_q == iorb_pkg::ST_FIND) ? in_q.seq : last_q + 32'd1;
		cmp_lt = rdata.seq < cmp_b;
		cmp_eq = rdata.seq == cmp_b;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iorb_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_fwd) begin
						state_d = iorb_pkg::ST_FWD;
					end else if (storable && has_room) begin
						state_d = (sequence_req > last_q) ? iorb_pkg::ST_FIND
							: iorb_pkg::ST_REPLY;
					end
				end
			end
			iorb_pkg::ST_FIND: begin
				if (at_end) begin
					state_d = iorb_pkg::ST_SHIFT;
				end else if (ph_q && !cmp_lt) begin
					state_d = cmp_eq ? iorb_pkg::ST_REL : iorb_pkg::ST_SHIFT;
				end
			end
			iorb_pkg::ST_SHIFT: begin
				if (at_hole) state_d = iorb_pkg::ST_REL;
			end
			iorb_pkg::ST_REL: begin
				if ((!ph_q && at_end) || (ph_q && !cmp_eq)) state_d = iorb_pkg::ST_COMPACT;
			end
			iorb_pkg::ST_COMPACT: begin
				if (pack_done) state_d = iorb_pkg::ST_INFO;
			end
			iorb_pkg::ST_INFO: state_d = iorb_pkg::ST_REPLY;
			iorb_pkg::ST_REPLY: state_d = iorb_pkg::ST_IDLE;
			iorb_pkg::ST_FWD: state_d = iorb_pkg::ST_IDLE;
		endcase
	end

	// Shifting walks from the top down: read ptr_q-1, then write it to ptr_q.
	always_comb begin
		we = 1'b0;
		waddr = ptr_q[IW-1:0];
		wdata = rdata;
		raddr = ptr_q[IW-1:0];
		unique case (state_q)
			iorb_pkg::ST_SHIFT: begin
				if (at_hole) begin
					we = 1'b1;
					waddr = sh_q[IW-1:0];
					wdata = in_q;
				end else begin
					raddr = IW'(ptr_q - CW'(1));
					we = ph_q;
				end
			end
			iorb_pkg::ST_COMPACT: begin
				raddr = src_idx[IW-1:0];
				we = ph_q && !pack_done;
			end
			iorb_pkg::ST_IDLE, iorb_pkg::ST_FIND, iorb_pkg::ST_REL,
			iorb_pkg::ST_INFO, iorb_pkg::ST_REPLY, iorb_pkg::ST_FWD: ;
		endcase
	end

	always_comb begin
		strobe = 1'b0;
		toward_network = 1'b0;
		out_kind = '0;
		out_sequence = '0;
		out_ack = '0;
		out_source = '0;
		out_dest = '0;
		free_slots = '0;
		out_payload = '0;
		last_of_run = 1'b0;
		unique case (state_q)
			iorb_pkg::ST_FWD: begin
				strobe = 1'b1;
				out_kind = in_q.kind;
				out_sequence = in_q.seq;
				out_ack = ack_q;
				out_source = in_q.src;
				out_dest = in_q.dst;
				out_payload = in_q.pay;
				last_of_run = 1'b1;
			end
			iorb_pkg::ST_REL: begin
				if (ph_q && cmp_eq) begin
					strobe = 1'b1;
					out_kind = rdata.kind;
					out_sequence = rdata.seq;
					out_source = rdata.src;
					out_dest = rdata.dst;
					out_payload = rdata.pay;
				end
			end
			iorb_pkg::ST_INFO: begin
				strobe = 1'b1;
				out_kind = iorb_pkg::K_INFO;
				free_slots = iorb_pkg::room(cnt_q);
			end
			iorb_pkg::ST_REPLY: begin
				strobe = 1'b1;
				toward_network = 1'b1;
				out_kind = reply_kind;
				out_ack = last_q;
				out_source = in_q.dst;
				out_dest = in_q.src;
				free_slots = iorb_pkg::room(cnt_q);
				last_of_run = 1'b1;
			end
			iorb_pkg::ST_IDLE, iorb_pkg::ST_FIND, iorb_pkg::ST_SHIFT,
			iorb_pkg::ST_COMPACT: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iorb_pkg::ST_IDLE;
			last_q <= '0;
			cnt_q <= '0;
			ptr_q <= '0;
			sh_q <= '0;
			rel_q <= '0;
			ph_q <= 1'b0;
			in_q <= '0;
			ack_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				iorb_pkg::ST_IDLE: begin
					ptr_q <= '0;
					rel_q <= '0;
					ph_q <= 1'b0;
					if (accept) begin
						in_q <= {kind, sequence_req, source_addr, dest_addr, payload_tag};
						ack_q <= ack_number;
					end
				end
				iorb_pkg::ST_FIND: begin
					if (at_end) begin
						sh_q <= ptr_q;
						ptr_q <= cnt_q;
						ph_q <= 1'b0;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (cmp_lt) begin
							ptr_q <= ptr_q + CW'(1);
						end else if (cmp_eq) begin
							// Duplicate: the older copy stays, go straight to release.
							ptr_q <= '0;
						end else begin
							sh_q <= ptr_q;
							ptr_q <= cnt_q;
						end
					end
				end
				iorb_pkg::ST_SHIFT: begin
					if (at_hole) begin
						cnt_q <= cnt_q + CW'(1);
						ptr_q <= '0;
						ph_q <= 1'b0;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ptr_q <= ptr_q - CW'(1);
						ph_q <= 1'b0;
					end
				end
				iorb_pkg::ST_REL: begin
					if (!ph_q) begin
						if (at_end) ptr_q <= '0;
						else ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (cmp_eq) begin
							last_q <= last_q + 32'd1;
							ptr_q <= ptr_q + CW'(1);
							rel_q <= rel_q + CW'(1);
						end else begin
							ptr_q <= '0;
						end
					end
				end
				iorb_pkg::ST_COMPACT: begin
					if (pack_done) begin
						cnt_q <= cnt_q - rel_q;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ptr_q <= ptr_q + CW'(1);
						ph_q <= 1'b0;
					end
				end
				iorb_pkg::ST_INFO, iorb_pkg::ST_REPLY, iorb_pkg::ST_FWD: ;
			endcase
		end
	end

	`IORB_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q < CW'(iorb_pkg::SLOTS))
	`IORB_ASSERT_IMP(a_last_has_strobe, clk, arst_n, last_of_run, strobe)
	`IORB_ASSERT_IMP(a_strobe_while_busy, clk, arst_n, strobe, busy)
	`IORB_ASSERT_NXT(a_run_ends_idle, clk, arst_n, last_of_run, state_q == iorb_pkg::ST_IDLE)
endmodule

// ===== dv/tb_in_order_receive_reorder_buffer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_in_order_receive_reorder_buffer_unit
// Drives packet headers into the reorder buffer and checks every result
// against a behavioral predictor of sorted holding and in-order release.
// ----------------------------------------------------------------------------
module tb_in_order_receive_reorder_buffer_unit;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic [3:0]  kind;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] pay;
		int          hold_off;
		bit          drain;
	} pkt_t;

	typedef struct {
		logic        net;
		logic [3:0]  kind;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [31:0] src;
		logic [31:0] dst;
		logic [3:0]  room;
		logic [31:0] pay;
		logic        last;
	} res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  kind;
	logic [31:0] sequence_req;
	logic [31:0] ack_number;
	logic [31:0] source_addr;
	logic [31:0] dest_addr;
	logic [31:0] payload_tag;
	logic        strobe;
	logic        toward_network;
	logic [3:0]  out_kind;
	logic [31:0] out_sequence;
	logic [31:0] out_ack;
	logic [31:0] out_source;
	logic [31:0] out_dest;
	logic [3:0]  free_slots;
	logic [31:0] out_payload;
	logic        last_of_run;

	pkt_t pending_pkts[$];
	res_t expected_results[$];
	int   mismatches;
	int   idle_cycles;
	int   gap_left;
	bit   stim_done;

	// Predictor state.
	logic [31:0] delivered = '0;
	int          held_n = 0;
	logic [31:0] h_seq[iorb_pkg::SLOTS];
	logic [3:0]  h_kind[iorb_pkg::SLOTS];
	logic [31:0] h_src[iorb_pkg::SLOTS];
	logic [31:0] h_dst[iorb_pkg::SLOTS];
	logic [31:0] h_pay[iorb_pkg::SLOTS];

	in_order_receive_reorder_buffer_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void queue_result(input res_t x);
		expected_results.insert(expected_results.size(), x);
	endfunction

	function automatic void queue_pkt(input pkt_t p);
		pending_pkts.insert(pending_pkts.size(), p);
	endfunction

	function automatic logic [3:0] room_left();
		return (held_n >= int'(iorb_pkg::SLOTS) - 1) ? 4'd0
			: 4'((int'(iorb_pkg::SLOTS) - 1 - held_n) & 15);
	endfunction

	function automatic res_t mk(logic net, logic [3:0] k, logic [31:0] s,
			logic [31:0] a, logic [31:0] sr, logic [31:0] d, logic [3:0] r,
			logic [31:0] p);
		res_t x;
		x.net = net; x.kind = k; x.seq = s; x.ack = a; x.src = sr;
		x.dst = d; x.room = r; x.pay = p; x.last = 1'b0;
		return x;
	endfunction

	task automatic predict_reorder(input pkt_t p);
		int pos;
		int nrel;
		res_t x;
		logic [3:0] reply;
		if (p.kind == iorb_pkg::K_ACK || p.kind == iorb_pkg::K_FINACK) begin
			x = mk(1'b0, p.kind, p.seq, p.ack, p.src, p.dst, 4'd0, p.pay);
			x.last = 1'b1;
			queue_result(x);
			return;
		end
		if (p.kind != iorb_pkg::K_DATA && p.kind != iorb_pkg::K_SYN
				&& p.kind != iorb_pkg::K_FIN)
			return;
		if (held_n >= int'(iorb_pkg::SLOTS) - 1)
			return;
		if (p.seq > delivered) begin
			pos = 0;
			while (pos < held_n && h_seq[pos] < p.seq)
				pos++;
			if (!(pos < held_n && h_seq[pos] == p.seq)) begin
				for (int i = held_n; i > pos; i--) begin
					h_seq[i] = h_seq[i-1]; h_kind[i] = h_kind[i-1];
					h_src[i] = h_src[i-1]; h_dst[i] = h_dst[i-1];
					h_pay[i] = h_pay[i-1];
				end
				h_seq[pos] = p.seq; h_kind[pos] = p.kind; h_src[pos] = p.src;
				h_dst[pos] = p.dst; h_pay[pos] = p.pay;
				held_n++;
			end
			nrel = 0;
			while (nrel < held_n && h_seq[nrel] == delivered + 32'd1) begin
				queue_result(mk(1'b0, h_kind[nrel], h_seq[nrel], 32'd0,
					h_src[nrel], h_dst[nrel], 4'd0, h_pay[nrel]));
				delivered++;
				nrel++;
			end
			for (int i = nrel; i < held_n; i++) begin
				h_seq[i-nrel] = h_seq[i]; h_kind[i-nrel] = h_kind[i];
				h_src[i-nrel] = h_src[i]; h_dst[i-nrel] = h_dst[i];
				h_pay[i-nrel] = h_pay[i];
			end
			held_n -= nrel;
			queue_result(mk(1'b0, iorb_pkg::K_INFO, 32'd0, 32'd0, 32'd0, 32'd0,
				room_left(), 32'd0));
		end
		reply = (p.kind == iorb_pkg::K_DATA) ? iorb_pkg::K_ACK
			: (p.kind == iorb_pkg::K_SYN) ? iorb_pkg::K_SYNACK : iorb_pkg::K_FINACK;
		x = mk(1'b1, reply, 32'd0, delivered, p.dst, p.src, room_left(), 32'd0);
		x.last = 1'b1;
		queue_result(x);
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 2) == 0)
			return 0;
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
	endfunction

	function automatic pkt_t mk_pkt(logic [3:0] k, logic [31:0] s);
		pkt_t p;
		p.kind = k; p.seq = s; p.ack = $urandom; p.src = $urandom;
		p.dst = $urandom; p.pay = $urandom;
		p.hold_off = pick_gap(); p.drain = 1'b0;
		return p;
	endfunction

	function automatic logic [3:0] stored_kind();
		case ($urandom_range(0, 2))
			0: return iorb_pkg::K_DATA;
			1: return iorb_pkg::K_SYN;
			default: return iorb_pkg::K_FIN;
		endcase
	endfunction

	// Stimulus: directed corners, then mostly windowed sequences near the
	// delivered point so that reordering, release runs and full buffers occur.
	initial begin
		pkt_t p;
		logic [31:0] base;
		p = mk_pkt(iorb_pkg::K_DATA, 32'd0); queue_pkt(p);      // old sequence
		p = mk_pkt(iorb_pkg::K_ACK, 32'hFFFF_FFFF); p.ack = 32'hFFFF_FFFF;
		p.src = 32'd0; p.dst = 32'hFFFF_FFFF; p.pay = 32'd0; queue_pkt(p);
		p = mk_pkt(iorb_pkg::K_FINACK, 32'd0); p.ack = 32'd0; p.src = 32'hFFFF_FFFF;
		p.dst = 32'd0; p.pay = 32'hFFFF_FFFF; queue_pkt(p);
		for (int k = 6; k < 16; k++) begin
			p = mk_pkt(4'(k), 32'd1); queue_pkt(p);
		end
		p = mk_pkt(iorb_pkg::K_SYNACK, 32'd1); queue_pkt(p);
		p = mk_pkt(iorb_pkg::K_SYN, 32'd3); queue_pkt(p);
		p = mk_pkt(iorb_pkg::K_FIN, 32'd3); queue_pkt(p);       // duplicate
		p = mk_pkt(iorb_pkg::K_DATA, 32'd2); queue_pkt(p);
		p = mk_pkt(iorb_pkg::K_DATA, 32'd1); p.drain = 1'b1; queue_pkt(p);
		// Hold fourteen entries out of order; the missing one releases them all.
		for (int i = 0; i < 14; i++) begin
			p = mk_pkt(stored_kind(), 32'd5 + 32'(i)); queue_pkt(p);
		end
		p = mk_pkt(iorb_pkg::K_DATA, 32'd4); queue_pkt(p);
		for (int i = 0; i < 200; i++) begin
			base = 32'd19 + 32'(i / 4);
			case ($urandom_range(0, 9))
				0: p = mk_pkt(4'($urandom_range(0, 15)), $urandom);
				1: p = mk_pkt(iorb_pkg::K_ACK + 4'(4 * $urandom_range(0, 1)), $urandom);
				2: p = mk_pkt(stored_kind(), 32'($urandom_range(0, 3)));
				default: p = mk_pkt(stored_kind(), base + 32'($urandom_range(0, 24)));
			endcase
			if (i == 120)
				p.drain = 1'b1;
			queue_pkt(p);
		end
		// High sequence values reach the upper bits.
		p = mk_pkt(iorb_pkg::K_DATA, 32'hFFFF_FFFF); queue_pkt(p);
		p = mk_pkt(iorb_pkg::K_DATA, 32'h8000_0000); queue_pkt(p);
		// Far-ahead sequences fill the buffer and then meet the full case.
		for (int i = 0; i < 16; i++) begin
			p = mk_pkt(stored_kind(), 32'h4000_0000 + 32'(i)); queue_pkt(p);
		end
	end

	task automatic p_drive(input pkt_t p);
		start <= 1'b1;
		kind <= p.kind; sequence_req <= p.seq; ack_number <= p.ack;
		source_addr <= p.src; dest_addr <= p.dst; payload_tag <= p.pay;
		gap_left <= p.hold_off;
	endtask

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			kind <= '0; sequence_req <= '0; ack_number <= '0;
			source_addr <= '0; dest_addr <= '0; payload_tag <= '0;
			gap_left <= 0;
			stim_done <= 1'b0;
		end else if (!(start && busy)) begin
			if (start)
				predict_reorder(pkt_t'{kind, sequence_req, ack_number, source_addr,
					dest_addr, payload_tag, 0, 1'b0});
			if (pending_pkts.size() == 0) begin
				start <= 1'b0;
				stim_done <= 1'b1;
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_pkts[0].drain && (start || expected_results.size() != 0
					|| busy)) begin
				start <= 1'b0;
			end else begin
				p_drive(pending_pkts.pop_front());
			end
		end
	end

	// Monitor and checker.
	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			mismatches <= 0;
			idle_cycles <= 0;
		end else begin
			idle_cycles <= (strobe || (start && !busy)) ? 0 : idle_cycles + 1;
			if (strobe) begin
				if (expected_results.size() == 0) begin
					if (mismatches < 10)
						$display("Unexpected result kind=%0d seq=%h", out_kind, out_sequence);
					mismatches <= mismatches + 1;
				end else begin
					e = expected_results.pop_front();
					if (e.net !== toward_network || e.kind !== out_kind
							|| e.seq !== out_sequence || e.ack !== out_ack
							|| e.src !== out_source || e.dst !== out_dest
							|| e.room !== free_slots || e.pay !== out_payload
							|| e.last !== last_of_run) begin
						if (mismatches < 10) begin
							$display("Mismatch: expected net=%b kind=%0d seq=%h ack=%h src=%h",
								e.net, e.kind, e.seq, e.ack, e.src);
							$display("  dst=%h room=%0d pay=%h last=%b", e.dst, e.room,
								e.pay, e.last);
							$display("  got net=%b kind=%0d seq=%h ack=%h src=%h",
								toward_network, out_kind, out_sequence, out_ack, out_source);
							$display("  dst=%h room=%0d pay=%h last=%b", out_dest,
								free_slots, out_payload, last_of_run);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
			if (stim_done && !start && !busy && expected_results.size() == 0) begin
				repeat (80) @(posedge clk);
				if (mismatches == 0 && expected_results.size() == 0)
					$display("Verification passed");
				else
					$display("Verification failed");
				$finish;
			end
		end
	end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/iorb_pkg.sv
rtl/core/iorb_store.sv
rtl/core/in_order_receive_reorder_buffer_unit.sv
dv/tb_in_order_receive_reorder_buffer_unit.sv
